>>> hdl/jsacal_pkg.sv
// Shared types and constants for the joystick axis auto-calibration block.
package jsacal_pkg;

	localparam int RAW_W           = 12;
	localparam int BTN_W           = 4;
	localparam int POS_W           = 16;
	localparam int STATE_W         = 8;
	localparam int QUO_W           = POS_W - 1;
	localparam int DIVR_W          = RAW_W + 1;
	localparam int CNT_W           = $clog2(QUO_W);
	localparam int COUNT_LIMIT_DEF = 2048;

	localparam logic [RAW_W-1:0]        SPAN_RESET = RAW_W'(32);
	localparam logic signed [POS_W-1:0] QUARTER    = POS_W'(16'h4000);

	typedef struct packed {
		logic [RAW_W-1:0] raw_x;
		logic [RAW_W-1:0] raw_y;
		logic [BTN_W-1:0] buttons;
	} in_item_t;

	typedef struct packed {
		logic signed [POS_W-1:0] pos_x;
		logic signed [POS_W-1:0] pos_y;
		logic [STATE_W-1:0]      state_bits;
		logic [STATE_W-1:0]      changed_bits;
		logic [STATE_W-1:0]      pressed_bits;
	} out_item_t;

	// Division operands and flags for the axis being scaled.
	typedef struct packed {
		logic [RAW_W-1:0]  dividend;
		logic [DIVR_W-1:0] divisor;
		logic              lower;
		logic              zero;
	} opnd_t;

endpackage

>>> hdl/jsacal_serial_div.sv
// Bit-serial restoring divider producing one quotient bit per cycle.
module jsacal_serial_div (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              start,
	input  logic [jsacal_pkg::RAW_W-1:0]      dividend,
	input  logic [jsacal_pkg::DIVR_W-1:0]     divisor,
	output logic                              done,
	output logic [jsacal_pkg::QUO_W-1:0]      quotient
);

	logic [jsacal_pkg::DIVR_W-1:0] rem_q;
	logic [jsacal_pkg::DIVR_W-1:0] dvs_q;
	logic [jsacal_pkg::QUO_W-1:0]  quo_q;
	logic [jsacal_pkg::CNT_W-1:0]  cnt_q;
	logic                          busy_q;
	logic                          done_q;
	logic [jsacal_pkg::DIVR_W:0]   trial;
	logic                          fits;

	// For in-range counts the dividend is below the divisor, so the remainder never
	// needs more than the divisor's width.
	assign trial = {rem_q, 1'b0};
	assign fits  = trial >= {1'b0, dvs_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == jsacal_pkg::CNT_W'(jsacal_pkg::QUO_W - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= {1'b0, dividend};
			dvs_q <= divisor;
		end else if (busy_q) begin
			if (fits) begin
				rem_q <= jsacal_pkg::DIVR_W'(trial - {1'b0, dvs_q});
			end else begin
				rem_q <= trial[jsacal_pkg::DIVR_W-1:0];
			end
			quo_q <= {quo_q[jsacal_pkg::QUO_W-2:0], fits};
		end
	end

	assign done     = done_q;
	assign quotient = quo_q;

endmodule

>>> hdl/jsacal_calib.sv
// Per-axis learned minimum, center and maximum, and the scaling operands.
module jsacal_calib #(
	parameter int COUNT_LIMIT = jsacal_pkg::COUNT_LIMIT_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          learn,
	input  logic                          axis,
	input  logic [jsacal_pkg::RAW_W-1:0]  raw,
	input  logic [jsacal_pkg::RAW_W-1:0]  min_span,
	output jsacal_pkg::opnd_t             opnd
);

	logic [jsacal_pkg::RAW_W-1:0] min_q    [2];
	logic [jsacal_pkg::RAW_W-1:0] center_q [2];
	logic [jsacal_pkg::RAW_W-1:0] max_q    [2];
	logic [jsacal_pkg::RAW_W-1:0] mn;
	logic [jsacal_pkg::RAW_W-1:0] ct;
	logic [jsacal_pkg::RAW_W-1:0] mx;
	logic                         raw_ok;
	logic                         lower;
	logic signed [jsacal_pkg::RAW_W:0] span;
	logic                         short_span;

	assign mn     = min_q[axis];
	assign ct     = center_q[axis];
	assign mx     = max_q[axis];
	assign raw_ok = 32'(raw) < COUNT_LIMIT;

	// A stored zero in the minimum or center means the entry is still unset.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int a = 0; a < 2; a++) begin
				min_q[a]    <= '0;
				center_q[a] <= '0;
				max_q[a]    <= '0;
			end
		end else if (learn && raw_ok) begin
			if (ct == '0) begin
				center_q[axis] <= raw;
			end
			if (mn == '0 || raw < mn) begin
				min_q[axis] <= raw;
			end
			if (raw > mx) begin
				max_q[axis] <= raw;
			end
		end
	end

	assign lower      = raw < ct;
	assign span       = $signed({1'b0, mx}) - $signed({1'b0, mn});
	assign short_span = span < $signed({1'b0, min_span});

	always_comb begin
		if (lower) begin
			opnd.dividend = raw - mn;
			opnd.divisor  = {1'b0, ct - mn};
		end else begin
			opnd.dividend = raw - ct;
			opnd.divisor  = {1'b0, mx - ct} + 1'b1;
		end
		opnd.lower = lower;
		opnd.zero  = !raw_ok || short_span || (lower && ct == mn);
	end

endmodule

>>> hdl/joystick_axis_autocal_normalizer_top.sv
// Top level of the joystick axis auto-calibration and normalization block.
//
//   Channel | Direction | Handshake               | Payload
//   --------+-----------+-------------------------+--------------------
//   in      | input     | in_valid / in_stall     | in_item  (in_item_t)
//   out     | output    | out_valid / out_stall   | out_item (out_item_t)
//   cfg     | input     | APB psel/penable/pready | min_span at address 0
//
// An update is in work for each axis in turn: learn, operand setup, 15 quotient
// bits and a done step in the shared bit-serial divider; a finish step then
// loads the output register. One transaction is in work at a time; in_stall is
// high until its result has been moved into the output register, so the next
// transaction is accepted only after that. A result still held by out_stall
// delays that move. Reset clears the learned calibration, the previous state
// bits and sets min_span to 32.
module joystick_axis_autocal_normalizer_top #(
	parameter int COUNT_LIMIT = jsacal_pkg::COUNT_LIMIT_DEF
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  in_valid,
	output logic                  in_stall,
	input  jsacal_pkg::in_item_t  in_item,
	output logic                  out_valid,
	input  logic                  out_stall,
	output jsacal_pkg::out_item_t out_item,
	input  logic                  psel,
	input  logic                  penable,
	input  logic                  pwrite,
	input  logic [2:0]            paddr,
	input  logic [31:0]           pwdata,
	output logic [31:0]           prdata,
	output logic                  pready
);

	localparam logic [2:0] S_IDLE   = 3'd0;
	localparam logic [2:0] S_LEARN  = 3'd1;
	localparam logic [2:0] S_PREP   = 3'd2;
	localparam logic [2:0] S_DIV    = 3'd3;
	localparam logic [2:0] S_FINISH = 3'd4;

	logic [2:0]                        state_q;
	logic                              axis_q;
	jsacal_pkg::in_item_t              item_q;
	logic [jsacal_pkg::RAW_W-1:0]      min_span_q;
	logic [jsacal_pkg::STATE_W-1:0]    prev_q;
	logic signed [jsacal_pkg::POS_W-1:0] pos_q [2];
	logic                              lower_q;
	logic                              zero_q;
	logic                              out_valid_q;
	jsacal_pkg::out_item_t             out_q;

	logic [jsacal_pkg::RAW_W-1:0]      raw_sel;
	jsacal_pkg::opnd_t                 opnd;
	logic                              div_done;
	logic [jsacal_pkg::QUO_W-1:0]      quotient;
	logic signed [jsacal_pkg::POS_W-1:0] pos_new;
	logic [jsacal_pkg::STATE_W-1:0]    state_bits;
	logic [jsacal_pkg::STATE_W-1:0]    diff_bits;
	logic                              cfg_wr;

	assign raw_sel = axis_q ? item_q.raw_y : item_q.raw_x;

	jsacal_calib #(
		.COUNT_LIMIT (COUNT_LIMIT)
	) u_calib (
		.clk      (clk),
		.arst_n   (arst_n),
		.learn    (state_q == S_LEARN),
		.axis     (axis_q),
		.raw      (raw_sel),
		.min_span (min_span_q),
		.opnd     (opnd)
	);

	jsacal_serial_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (state_q == S_PREP),
		.dividend (opnd.dividend),
		.divisor  (opnd.divisor),
		.done     (div_done),
		.quotient (quotient)
	);

	// Below center the quotient is offset by -32768, which only sets the sign bit.
	always_comb begin
		if (zero_q) begin
			pos_new = '0;
		end else begin
			pos_new = {lower_q, quotient};
		end
	end

	always_comb begin
		state_bits = {item_q.buttons,
			pos_q[1] > jsacal_pkg::QUARTER, pos_q[1] <= -jsacal_pkg::QUARTER,
			pos_q[0] > jsacal_pkg::QUARTER, pos_q[0] <= -jsacal_pkg::QUARTER};
		diff_bits = state_bits ^ prev_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			axis_q      <= 1'b0;
			prev_q      <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (out_valid_q && !out_stall && state_q != S_FINISH) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (in_valid) begin
						axis_q  <= 1'b0;
						state_q <= S_LEARN;
					end
				end
				S_LEARN: begin
					state_q <= S_PREP;
				end
				S_PREP: begin
					state_q <= S_DIV;
				end
				S_DIV: begin
					if (div_done) begin
						if (axis_q) begin
							state_q <= S_FINISH;
						end else begin
							axis_q  <= 1'b1;
							state_q <= S_LEARN;
						end
					end
				end
				S_FINISH: begin
					if (!out_valid_q || !out_stall) begin
						out_valid_q <= 1'b1;
						prev_q      <= state_bits;
						state_q     <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == S_IDLE && in_valid) begin
			item_q <= in_item;
		end
		if (state_q == S_PREP) begin
			lower_q <= opnd.lower;
			zero_q  <= opnd.zero;
		end
		if (state_q == S_DIV && div_done) begin
			pos_q[axis_q] <= pos_new;
		end
		if (state_q == S_FINISH && (!out_valid_q || !out_stall)) begin
			out_q.pos_x        <= pos_q[0];
			out_q.pos_y        <= pos_q[1];
			out_q.state_bits   <= state_bits;
			out_q.changed_bits <= diff_bits;
			out_q.pressed_bits <= state_bits & diff_bits;
		end
	end

	// Configuration register file: min_span is the only register.
	assign cfg_wr = psel && penable && pwrite && pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			min_span_q <= jsacal_pkg::SPAN_RESET;
		end else if (cfg_wr && !paddr[2]) begin
			min_span_q <= pwdata[jsacal_pkg::RAW_W-1:0];
		end
	end

	always_comb begin
		if (!paddr[2]) begin
			prdata = {(32 - jsacal_pkg::RAW_W)'(0), min_span_q};
		end else begin
			prdata = '0;
		end
	end

	assign pready    = 1'b1;
	assign in_stall  = state_q != S_IDLE;
	assign out_valid = out_valid_q;
	assign out_item  = out_q;

endmodule

>>> bench/joystick_axis_autocal_normalizer_top_tb.sv
// Self-checking testbench for the joystick axis auto-calibration normalizer.
`timescale 1ns / 100ps

module joystick_axis_autocal_normalizer_top_tb;

	localparam logic [2:0] SPAN_ADDR     = 3'd0;
	localparam logic [2:0] UNMAPPED_ADDR = 3'd4;
	localparam int         CYCLE_LIMIT   = 2_000_000;
	localparam int         DRAIN_CYCLES  = 60;
	localparam int         SWEEP_PHASES  = 10;
	localparam int         SWEEP_UPDATES = 195;

	logic                  clk;
	logic                  arst_n;
	logic                  in_valid;
	logic                  in_stall;
	jsacal_pkg::in_item_t  in_item;
	logic                  out_valid;
	logic                  out_stall;
	jsacal_pkg::out_item_t out_item;
	logic                  psel;
	logic                  penable;
	logic                  pwrite;
	logic [2:0]            paddr;
	logic [31:0]           pwdata;
	logic [31:0]           prdata;
	logic                  pready;

	// Calibration tracked by the predictor, one entry per axis (0 = x, 1 = y).
	logic [jsacal_pkg::RAW_W-1:0]   cal_min[2];
	logic [jsacal_pkg::RAW_W-1:0]   cal_center[2];
	logic [jsacal_pkg::RAW_W-1:0]   cal_max[2];
	logic [jsacal_pkg::STATE_W-1:0] last_state;
	logic [jsacal_pkg::RAW_W-1:0]   span_limit;

	jsacal_pkg::out_item_t expected_reports[$];
	int        failures;
	int        cycle_count;
	bit        idle_off;
	int        stick_mid[2];
	int        stick_reach[2];

	joystick_axis_autocal_normalizer_top i_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.in_item  (in_item),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.out_item (out_item),
		.psel     (psel),
		.penable  (penable),
		.pwrite   (pwrite),
		.paddr    (paddr),
		.pwdata   (pwdata),
		.prdata   (prdata),
		.pready   (pready)
	);

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (idle_off || r < 60) begin
			return 0;
		end
		if (r < 92) begin
			return $urandom_range(1, 3);
		end
		return $urandom_range(10, 50);
	endfunction

	// Learns from one axis count and returns the scaled position.
	function automatic int scale_axis(input int a, input logic [jsacal_pkg::RAW_W-1:0] raw);
		int r;
		int pos;
		int rng;
		r   = raw;
		pos = 0;
		if (r < jsacal_pkg::COUNT_LIMIT_DEF) begin
			// A stored zero counts as unset, so any valid count replaces it.
			if (cal_center[a] == '0) begin
				cal_center[a] = raw;
			end
			if (cal_min[a] == '0 || raw < cal_min[a]) begin
				cal_min[a] = raw;
			end
			if (raw > cal_max[a]) begin
				cal_max[a] = raw;
			end
			if (r < int'(cal_center[a])) begin
				rng = int'(cal_center[a]) - int'(cal_min[a]);
				if (rng != 0 && r >= int'(cal_min[a])) begin
					pos = ((r - int'(cal_min[a])) <<< 15) / rng - 32'h8000;
				end
			end else begin
				rng = int'(cal_max[a]) - int'(cal_center[a]) + 1;
				if (int'(cal_max[a]) >= r && rng != 0) begin
					pos = ((r - int'(cal_center[a])) <<< 15) / rng;
				end
			end
		end
		if (int'(cal_max[a]) - int'(cal_min[a]) < int'(span_limit)) begin
			pos = 0;
		end
		if (pos > 32767) begin
			pos = 32767;
		end
		if (pos < -32768) begin
			pos = -32768;
		end
		return pos;
	endfunction

	function automatic jsacal_pkg::out_item_t predict_report(input jsacal_pkg::in_item_t upd);
		jsacal_pkg::out_item_t          rep;
		logic [jsacal_pkg::STATE_W-1:0] st;
		logic [jsacal_pkg::STATE_W-1:0] diff;
		int                             pos[2];
		st     = '0;
		st[7:4] = upd.buttons;
		pos[0] = scale_axis(0, upd.raw_x);
		pos[1] = scale_axis(1, upd.raw_y);
		for (int a = 0; a < 2; a++) begin
			if (pos[a] <= -int'(jsacal_pkg::QUARTER)) begin
				st[2*a] = 1'b1;
			end else if (pos[a] > int'(jsacal_pkg::QUARTER)) begin
				st[2*a+1] = 1'b1;
			end
		end
		diff             = st ^ last_state;
		last_state       = st;
		rep.pos_x        = pos[0][jsacal_pkg::POS_W-1:0];
		rep.pos_y        = pos[1][jsacal_pkg::POS_W-1:0];
		rep.state_bits   = st;
		rep.changed_bits = diff;
		rep.pressed_bits = st & diff;
		return rep;
	endfunction

	function automatic void check_field(input string name, input logic [31:0] want,
			input logic [31:0] got);
		if (want !== got) begin
			$error("%s: expected %h, actual %h", name, want, got);
			failures++;
		end
	endfunction

	task automatic send_update(input jsacal_pkg::in_item_t upd);
		int gap;
		gap = pick_gap();
		@(negedge clk);
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		in_item  <= upd;
		in_valid <= 1'b1;
		do @(posedge clk); while (in_stall);
		expected_reports.push_back(predict_report(upd));
	endtask

	task automatic send_xy(input int x, input int y, input int btn);
		jsacal_pkg::in_item_t upd;
		upd.raw_x   = jsacal_pkg::RAW_W'(x);
		upd.raw_y   = jsacal_pkg::RAW_W'(y);
		upd.buttons = jsacal_pkg::BTN_W'(btn);
		send_update(upd);
	endtask

	// Lowers valid and waits until every expected report has come out.
	task automatic drain_updates();
		@(negedge clk);
		in_valid <= 1'b0;
		while (expected_reports.size() != 0) @(negedge clk);
	endtask

	task automatic apb_access(input logic [2:0] addr, input logic wr, input logic [31:0] data,
			output logic [31:0] rdata);
		@(negedge clk);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= wr;
		paddr   <= addr;
		pwdata  <= data;
		@(negedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		rdata = prdata;
		@(negedge clk);
		psel    <= 1'b0;
		penable <= 1'b0;
	endtask

	// Writes a register while the block is idle and reads the span limit back.
	task automatic write_span(input logic [2:0] addr, input logic [31:0] data);
		logic [31:0] rdata;
		drain_updates();
		apb_access(addr, 1'b1, data, rdata);
		if (addr == SPAN_ADDR) begin
			span_limit = data[jsacal_pkg::RAW_W-1:0];
		end
		apb_access(SPAN_ADDR, 1'b0, '0, rdata);
		check_field("min_span", 32'(span_limit), rdata);
	endtask

	task automatic test_no_reading();
		send_xy(2048, 4095, 4'h0);
		send_xy(4095, 2048, 4'hf);
		send_xy(3000, 2049, 4'h0);
	endtask

	// Default span limit of 32: positions stay centered until the span reaches it.
	task automatic test_short_span();
		send_xy(1000, 1800, 4'h5);
		send_xy(1010, 1790, 4'ha);
		send_xy(1031, 1769, 4'h5);
		send_xy(1032, 1768, 4'ha);
	endtask

	task automatic test_zero_reading();
		send_xy(0, 0, 4'h1);
		send_xy(600, 2047, 4'h2);
		send_xy(800, 1900, 4'h4);
	endtask

	task automatic test_extremes();
		send_xy(2047, 1, 4'hf);
		send_xy(1, 2047, 4'h0);
		send_xy(2047, 2048, 4'h8);
		send_xy(1000, 1800, 4'h0);
		send_xy(1500, 500, 4'hf);
	endtask

	task automatic test_span_register();
		write_span(SPAN_ADDR, 32'd0);
		send_xy(1200, 1700, 4'h3);
		send_xy(700, 1950, 4'hc);
		write_span(SPAN_ADDR, 32'd2048);
		send_xy(2047, 1, 4'h6);
		send_xy(0, 100, 4'h9);
		// Writes to an unmapped address must leave the span limit alone.
		write_span(UNMAPPED_ADDR, 32'h0000_0005);
		send_xy(300, 1000, 4'h0);
		// Bits above the register width are dropped.
		write_span(SPAN_ADDR, 32'hffff_f7ff);
		send_xy(1999, 1400, 4'hf);
	endtask

	function automatic logic [jsacal_pkg::RAW_W-1:0] draw_raw(input int a);
		int r;
		int v;
		r = $urandom_range(0, 99);
		if (r < 8) begin
			return jsacal_pkg::RAW_W'($urandom_range(2048, 4095));
		end
		if (r < 12) begin
			return '0;
		end
		if (r < 15) begin
			return jsacal_pkg::RAW_W'($urandom_range(0, 4095));
		end
		v = stick_mid[a] + int'($urandom_range(0, 2 * stick_reach[a])) - stick_reach[a];
		if (v < 1) begin
			v = 1;
		end
		if (v > jsacal_pkg::COUNT_LIMIT_DEF - 1) begin
			v = jsacal_pkg::COUNT_LIMIT_DEF - 1;
		end
		return jsacal_pkg::RAW_W'(v);
	endfunction

	// Stick sweeps around a random rest point, with dropouts and zero counts mixed in.
	task automatic test_random_sweeps();
		jsacal_pkg::in_item_t upd;
		for (int ph = 0; ph < SWEEP_PHASES; ph++) begin
			case (ph % 5)
				0: write_span(SPAN_ADDR, 32'd0);
				1: write_span(SPAN_ADDR, 32'd2048);
				2: write_span(SPAN_ADDR, $urandom_range(0, 2048));
				3: write_span(SPAN_ADDR, 32'd32 | ($urandom & 32'hffff_f000));
				default: write_span(SPAN_ADDR, $urandom);
			endcase
			idle_off = (ph % 3 == 1);
			for (int a = 0; a < 2; a++) begin
				stick_mid[a]   = $urandom_range(200, 1850);
				stick_reach[a] = ($urandom_range(0, 3) == 0) ? $urandom_range(5, 60)
					: $urandom_range(100, 1500);
			end
			for (int n = 0; n < SWEEP_UPDATES; n++) begin
				upd.raw_x   = draw_raw(0);
				upd.raw_y   = draw_raw(1);
				upd.buttons = jsacal_pkg::BTN_W'($urandom);
				send_update(upd);
			end
		end
		idle_off = 1'b0;
	endtask

	initial begin
		int hold;
		hold      = 0;
		out_stall = 1'b0;
		forever begin
			@(negedge clk);
			if (hold > 0) begin
				hold--;
				out_stall <= 1'b1;
			end else begin
				hold = pick_gap();
				out_stall <= (hold > 0);
				if (hold > 0) begin
					hold--;
				end
			end
		end
	end

	always @(posedge clk) begin
		jsacal_pkg::out_item_t want;
		if (arst_n && out_valid && !out_stall) begin
			if (expected_reports.size() == 0) begin
				$error("unexpected report %h", out_item);
				failures++;
			end else begin
				want = expected_reports.pop_front();
				check_field("pos_x", 32'(want.pos_x), 32'(out_item.pos_x));
				check_field("pos_y", 32'(want.pos_y), 32'(out_item.pos_y));
				check_field("state_bits", 32'(want.state_bits), 32'(out_item.state_bits));
				check_field("changed_bits", 32'(want.changed_bits), 32'(out_item.changed_bits));
				check_field("pressed_bits", 32'(want.pressed_bits), 32'(out_item.pressed_bits));
			end
		end
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("FAIL");
			$finish;
		end
	end

	initial begin
		arst_n      = 1'b0;
		in_valid    = 1'b0;
		in_item     = '0;
		psel        = 1'b0;
		penable     = 1'b0;
		pwrite      = 1'b0;
		paddr       = '0;
		pwdata      = '0;
		failures    = 0;
		cycle_count = 0;
		idle_off    = 1'b0;
		for (int a = 0; a < 2; a++) begin
			cal_min[a]    = '0;
			cal_center[a] = '0;
			cal_max[a]    = '0;
		end
		last_state = '0;
		span_limit = jsacal_pkg::SPAN_RESET;
		repeat (9) @(negedge clk);
		arst_n <= 1'b1;

		test_no_reading();
		test_short_span();
		test_zero_reading();
		test_extremes();
		test_span_register();
		test_random_sweeps();

		drain_updates();
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (failures == 0) begin
			$display("PASS");
		end else begin
			$display("FAIL");
		end
		$finish;
	end

endmodule

>>> joystick_axis_autocal_normalizer_top.f
hdl/jsacal_pkg.sv
hdl/jsacal_serial_div.sv
hdl/jsacal_calib.sv
hdl/joystick_axis_autocal_normalizer_top.sv
bench/joystick_axis_autocal_normalizer_top_tb.sv
